/* hdl/gpr_pkg.sv */
package gpr_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int PIXEL_COUNT = 1024;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CFG_W  = 5;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 10;
    localparam int CH_W   = 8;
    localparam int NCH    = 3;
    localparam int RGB_W  = NCH * CH_W;
    localparam int ENT_W  = POS_W + RGB_W;

    // quotient stays below 256 while the step is below the span
    localparam int QUO_W = CH_W;
    localparam int DVD_W = CH_W + POS_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - RGB_W;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    // channel 0 is blue, 1 green, 2 red
    typedef struct packed {
        logic [POS_W-1:0]           pixel;
        logic                       defined;
        logic                       blend;
        logic [NCH-1:0]             neg;
        logic [NCH-1:0][CH_W-1:0]   base;
    } side_t;

    typedef struct packed {
        logic [NCH-1:0][DVD_W-1:0]  rem;
        logic [NCH-1:0][QUO_W-1:0]  quo;
        logic [POS_W-1:0]           span;
        side_t                      side;
    } dstage_t;

endpackage

/* hdl/gradient_pixel_renderer_top.sv */
// Piecewise linear colour gradient renderer. Point items (tuser 0) load one table slot with a
// position and a colour; render items (tuser 1) return the colour of one pixel, blended
// between the two points around it, or flat outside the outermost points; color_defined is
// low and the colour black while cfg point_count is zero. Point items give no result. The
// block takes one item per clock while the result side keeps up: every pixel's points are
// matched against all sixteen positions at once, the colour table has two read ports, and the
// per-channel division runs through an eight-stage restoring divider, one quotient bit a
// stage. Stalls are absorbed by empty stages before they reach the input. A point item
// takes effect for every render item accepted after it.
module gradient_pixel_renderer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point_slot, point_position, point_red, point_green, point_blue, pixel_index
    input  logic [gpr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_number, out_red, out_green, out_blue, zero padding
    output logic [gpr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // color_defined
    output logic                              m_axis_tuser,
    input  logic                              cfg_wr_en,
    input  logic [gpr_pkg::CFG_W-1:0]         cfg_wr_data
);
    import gpr_pkg::*;

    logic [CFG_W-1:0] point_count_reg;
    logic [CNT_W-1:0] n_eff;

    // unpacked input fields
    op_t               in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [POS_W-1:0]  in_pos;
    logic [RGB_W-1:0]  in_rgb;
    logic [POS_W-1:0]  in_pix;

    logic ld0, ld1, ld2, ld3, ld4, ld_out;

    // input stage
    logic              s0_v_reg, s0_v_next;
    op_t               s0_op_reg;
    logic [SLOT_W-1:0] s0_slot_reg;
    logic [POS_W-1:0]  s0_pos_reg;
    logic [RGB_W-1:0]  s0_rgb_reg;
    logic [POS_W-1:0]  s0_pix_reg;

    // position compare stage
    logic [POS_W-1:0]      pos_reg [MAX_POINTS];
    logic [MAX_POINTS-1:0] hit_next;
    logic                  s1_v_reg;
    op_t                   s1_op_reg;
    logic [SLOT_W-1:0]     s1_slot_reg;
    logic [POS_W-1:0]      s1_pos_reg;
    logic [RGB_W-1:0]      s1_rgb_reg;
    logic [POS_W-1:0]      s1_pix_reg;
    logic [MAX_POINTS-1:0] s1_hit_reg;
    logic [IDX_W-1:0]      sel;
    logic [IDX_W-1:0]      sel_nxt_addr;
    logic                  found;
    logic                  has_next;
    logic                  tbl_we;

    // table read stage
    logic [ENT_W-1:0] tbl_mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;
    logic             s2_v_reg;
    logic [POS_W-1:0] s2_pix_reg;
    logic             s2_found_reg;
    logic             s2_next_reg;

    // segment set-up stage
    logic [POS_W-1:0]          pos_a, pos_b;
    side_t                     s3_side_next;
    logic [NCH-1:0][CH_W-1:0]  mag_next;
    logic                      s3_v_reg;
    side_t                     s3_side_reg;
    logic [NCH-1:0][CH_W-1:0]  s3_mag_reg;
    logic [POS_W-1:0]          s3_step_reg;
    logic [POS_W-1:0]          s3_span_reg;

    // product stage
    dstage_t s4_next;
    logic    s4_v_reg;
    dstage_t s4_reg;

    logic    div_in_ready;
    logic    div_out_valid;
    dstage_t div_out;

    // result register
    logic [NCH-1:0][CH_W-1:0] m_ch_next;
    logic                     m_v_reg;
    logic [POS_W-1:0]         m_pix_reg;
    logic [NCH-1:0][CH_W-1:0] m_ch_reg;
    logic                     m_def_reg;

    assign in_op   = op_t'(s_axis_tuser);
    assign in_slot = s_axis_tdata[3:0];
    assign in_pos  = s_axis_tdata[13:4];
    assign in_rgb  = {s_axis_tdata[21:14], s_axis_tdata[29:22], s_axis_tdata[37:30]};
    assign in_pix  = s_axis_tdata[47:38];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= '0;
        end else if (cfg_wr_en) begin
            point_count_reg <= cfg_wr_data;
        end
    end

    assign n_eff = (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                       : CNT_W'(point_count_reg);

    // load enables, from the result end back to the input
    assign ld_out = !m_v_reg || m_axis_tready;
    assign ld4    = !s4_v_reg || div_in_ready;
    assign ld3    = !s3_v_reg || ld4;
    assign ld2    = !s2_v_reg || ld3;
    assign ld1    = !s1_v_reg || ld2;
    assign ld0    = !s0_v_reg || ld1;

    assign s_axis_tready = ld0;

    // drop render items for pixels off the strip
    assign s0_v_next = s_axis_tvalid && (in_op == OP_WRITE || 32'(in_pix) < PIXEL_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (ld0) begin
            s0_v_reg <= s0_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            s0_op_reg   <= in_op;
            s0_slot_reg <= in_slot;
            s0_pos_reg  <= in_pos;
            s0_rgb_reg  <= in_rgb;
            s0_pix_reg  <= in_pix;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            hit_next[i] = (pos_reg[i] <= s0_pix_reg) && (CNT_W'(i) < n_eff);
        end
    end

    // positions are written as the point item leaves the input stage
    always_ff @(posedge aclk) begin
        if (ld1 && s0_v_reg && s0_op_reg == OP_WRITE && 32'(s0_slot_reg) < MAX_POINTS) begin
            pos_reg[IDX_W'(s0_slot_reg)] <= s0_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (ld1) begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_op_reg   <= s0_op_reg;
            s1_slot_reg <= s0_slot_reg;
            s1_pos_reg  <= s0_pos_reg;
            s1_rgb_reg  <= s0_rgb_reg;
            s1_pix_reg  <= s0_pix_reg;
            s1_hit_reg  <= hit_next;
        end
    end

    // last point at or before the pixel; slot 0 when there is none
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (s1_hit_reg[i]) begin
                sel   = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign sel_nxt_addr = sel + IDX_W'(1);
    assign has_next     = (CNT_W'(sel) + CNT_W'(1)) < n_eff;

    // colours are written one stage later, where render items read them
    assign tbl_we = ld2 && s1_v_reg && s1_op_reg == OP_WRITE && 32'(s1_slot_reg) < MAX_POINTS;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[IDX_W'(s1_slot_reg)] <= {s1_pos_reg, s1_rgb_reg};
        end
        if (ld2) begin
            rd_a_reg <= tbl_mem[sel];
            rd_b_reg <= tbl_mem[sel_nxt_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (ld2) begin
            s2_v_reg <= s1_v_reg && s1_op_reg == OP_RENDER;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_pix_reg   <= s1_pix_reg;
            s2_found_reg <= found;
            s2_next_reg  <= has_next;
        end
    end

    assign pos_a = rd_a_reg[ENT_W-1 -: POS_W];
    assign pos_b = rd_b_reg[ENT_W-1 -: POS_W];

    always_comb begin
        logic [CH_W-1:0] ca;
        logic [CH_W-1:0] cb;
        s3_side_next.pixel   = s2_pix_reg;
        s3_side_next.defined = n_eff != '0;
        s3_side_next.blend   = s2_found_reg && s2_next_reg && pos_a != s2_pix_reg;
        for (int c = 0; c < NCH; c++) begin
            ca = rd_a_reg[c*CH_W +: CH_W];
            cb = rd_b_reg[c*CH_W +: CH_W];
            s3_side_next.base[c] = ca;
            s3_side_next.neg[c]  = cb < ca;
            mag_next[c]          = (cb < ca) ? ca - cb : cb - ca;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else if (ld3) begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            s3_side_reg <= s3_side_next;
            s3_mag_reg  <= mag_next;
            s3_step_reg <= s2_pix_reg - pos_a;
            s3_span_reg <= pos_b - pos_a;
        end
    end

    always_comb begin
        s4_next      = '0;
        s4_next.span = s3_span_reg;
        s4_next.side = s3_side_reg;
        for (int c = 0; c < NCH; c++) begin
            s4_next.rem[c] = DVD_W'(s3_mag_reg[c]) * DVD_W'(s3_step_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_v_reg <= 1'b0;
        end else if (ld4) begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            s4_reg <= s4_next;
        end
    end

    gpr_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s4_v_reg),
        .in_ready  (div_in_ready),
        .in_data   (s4_reg),
        .out_valid (div_out_valid),
        .out_ready (ld_out),
        .out_data  (div_out)
    );

    // apply the signed quotient to the segment start colour
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (!div_out.side.defined) begin
                m_ch_next[c] = '0;
            end else if (!div_out.side.blend) begin
                m_ch_next[c] = div_out.side.base[c];
            end else if (div_out.side.neg[c]) begin
                m_ch_next[c] = div_out.side.base[c] - div_out.quo[c];
            end else begin
                m_ch_next[c] = div_out.side.base[c] + div_out.quo[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (ld_out) begin
            m_v_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_pix_reg <= div_out.side.pixel;
            m_ch_reg  <= m_ch_next;
            m_def_reg <= div_out.side.defined;
        end
    end

    assign m_axis_tvalid = m_v_reg;
    assign m_axis_tdata  = {M_PAD_W'(0), m_ch_reg[0], m_ch_reg[1], m_ch_reg[2], m_pix_reg};
    assign m_axis_tuser  = m_def_reg;

endmodule

/* hdl/gpr_div_pipe.sv */
module gpr_div_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gpr_pkg::dstage_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gpr_pkg::dstage_t  out_data
);
    import gpr_pkg::*;

    dstage_t          st_reg  [QUO_W];
    dstage_t          st_prev [QUO_W];
    dstage_t          st_next [QUO_W];
    logic [QUO_W-1:0] v_reg;
    logic [QUO_W-1:0] v_next;
    logic [QUO_W-1:0] ld;

    // a stage loads when it is empty or its item moves on
    always_comb begin
        ld[QUO_W-1] = !v_reg[QUO_W-1] || out_ready;
        for (int k = QUO_W - 2; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    // one restoring step per stage, quotient bits from the top down
    always_comb begin
        logic [DVD_W-1:0] trial;
        st_prev[0] = in_data;
        v_next[0]  = in_valid;
        for (int k = 1; k < QUO_W; k++) begin
            st_prev[k] = st_reg[k-1];
            v_next[k]  = v_reg[k-1];
        end
        for (int k = 0; k < QUO_W; k++) begin
            st_next[k] = st_prev[k];
            for (int c = 0; c < NCH; c++) begin
                trial = DVD_W'(st_prev[k].span) << (QUO_W - 1 - k);
                if (st_prev[k].rem[c] >= trial) begin
                    st_next[k].rem[c]              = st_prev[k].rem[c] - trial;
                    st_next[k].quo[c][QUO_W-1-k]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < QUO_W; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUO_W; k++) begin
            if (ld[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[QUO_W-1];
    assign out_data  = st_reg[QUO_W-1];

endmodule

/* hdl/gpr_port_checker.sv */
module gpr_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import gpr_pkg::*;

    // nothing is offered in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    // a waiting item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1 -: M_PAD_W] == '0)
        else $error("padding bits of result not zero");

    // empty gradient renders black
    a_undef_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[POS_W +: RGB_W] == '0)
        else $error("undefined colour not black");

endmodule

bind gradient_pixel_renderer_top gpr_port_checker u_port_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
